>>> rtl/stu_pkg.sv
// Package: shared types, constants and digit decode for the string to unsigned parser.
package stu_pkg;

    // Width of the saturating character position counter
    localparam int unsigned OFFSET_BITS = 16;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    // Field widths
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BASE_W  = 5;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned OFFS_W  = 16;
    localparam int unsigned OUT_W   = VALUE_W + OFFS_W;

    // Characters and bases of interest
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

    // Parse phases
    typedef enum logic [2:0] {
        PH_SKIP,
        PH_ZERO,
        PH_DIGITS,
        PH_DRAIN
    } t_phase;

    // Parser state carried between characters
    typedef struct packed {
        t_phase                 phase;
        logic [VALUE_W-1:0]     acc;
        logic [OFFSET_BITS-1:0] pos;
        logic [BASE_W-1:0]      base;
    } t_state;

    // Decoded digit: ok marks 0-9, a-f, A-F
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    function automatic t_digit digit_decode(input logic [CHAR_W-1:0] c);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

>>> rtl/string_to_unsigned_parser_top.sv
// Top level: unsigned integer parser over a byte stream with a two-entry result buffer.
//
// Usage:
//   Characters of a NUL-terminated string enter on the s_axis channel, one byte in
//   tdata per transaction. Leading space, tab and newline are skipped, an optional
//   0x/0X prefix is stripped in base 0 or 16, and digits are accumulated mod 2^64.
//   The first zero or non-digit byte produces one result transaction on m_axis:
//   the value and the offset of that byte. Bytes after it are dropped through the
//   terminating zero.
//   The base is written on the cfg channel (always ready) while the block is idle;
//   zero selects detection from the prefix.
//   Throughput: one character per cycle while s_axis_tready is high; each character
//   is decoded and the multiply-accumulate (accumulator times a 5-bit base) done
//   combinationally. The result is registered before it is valid on m_axis.
//   Stall: results sit in an output register plus one skid entry; s_axis_tready
//   drops only while both are full, so input keeps flowing past one held result.
//   Reset (i_rst_n low, synchronous): parser restarts in the whitespace phase,
//   base register returns to 0, and the result buffer empties.
module string_to_unsigned_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: base_mode
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stu_pkg::BASE_W-1:0]    i_cfg_data,
    // input characters
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [stu_pkg::CHAR_W-1:0]    s_axis_tdata,  // [7:0] char_byte
    // results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [stu_pkg::OUT_W-1:0]     m_axis_tdata   // [63:0] parsed_value,
                                                         // [79:64] end_offset
);

    logic [stu_pkg::BASE_W-1:0]      r_base_mode;
    stu_pkg::t_state                 r_state;
    stu_pkg::t_state                 n_state;
    logic                            step_emit;
    logic [stu_pkg::VALUE_W-1:0]     step_value;
    logic [stu_pkg::OFFSET_BITS-1:0] step_offset;
    logic [stu_pkg::OUT_W-1:0]       step_data;

    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [stu_pkg::OUT_W-1:0]       r_out_data;
    logic [stu_pkg::OUT_W-1:0]       n_out_data;
    logic                            r_skid_valid;
    logic                            n_skid_valid;
    logic [stu_pkg::OUT_W-1:0]       r_skid_data;
    logic [stu_pkg::OUT_W-1:0]       n_skid_data;

    logic                            in_acc;
    logic                            out_take;
    logic                            new_res;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_mode <= stu_pkg::BASE_AUTO;
        end else if (i_cfg_valid) begin
            r_base_mode <= i_cfg_data;
        end
    end

    // Per-character parse logic
    stu_step u_step (
        .i_char      (s_axis_tdata),
        .i_base_mode (r_base_mode),
        .i_cur       (r_state),
        .o_nxt       (n_state),
        .o_emit      (step_emit),
        .o_value     (step_value),
        .o_offset    (step_offset)
    );

    assign step_data = {stu_pkg::OFFS_W'(step_offset), step_value};

    // Handshakes
    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;
    assign new_res       = in_acc && step_emit;

    // Advance parser state on each accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= stu_pkg::PH_SKIP;
            r_state.acc   <= '0;
            r_state.pos   <= '0;
            r_state.base  <= stu_pkg::BASE_AUTO;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Result buffer: output register backed by one skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid  = new_res;
                n_out_data   = step_data;
            end
        end else if (new_res) begin
            n_skid_valid = 1'b1;
            n_skid_data  = step_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Hold payload without reset
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Skid entry is used only behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // A result arriving at a stalled output lands in the skid entry
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_res && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("result lost behind stalled output");

    // A result arriving at an empty buffer shows up next cycle with its data
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (new_res && !r_out_valid) |=> (r_out_valid && m_axis_tdata == $past(step_data)))
        else $error("result not presented");

    // Drain phase is entered only together with a result
    a_drain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_state.phase == stu_pkg::PH_DRAIN && r_state.phase != stu_pkg::PH_DRAIN)
        |-> step_emit)
        else $error("drain entered without a result");

    // Position saturates rather than wrapping
    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.pos == stu_pkg::POS_MAX && n_state.pos != '0)
        |=> r_state.pos == stu_pkg::POS_MAX)
        else $error("character position wrapped");

endmodule

>>> rtl/stu_step.sv
// Module: next-state and result logic of the parser for one character.
module stu_step (
    input  logic [stu_pkg::CHAR_W-1:0]      i_char,
    input  logic [stu_pkg::BASE_W-1:0]      i_base_mode,
    input  stu_pkg::t_state                 i_cur,
    output stu_pkg::t_state                 o_nxt,
    output logic                            o_emit,
    output logic [stu_pkg::VALUE_W-1:0]     o_value,
    output logic [stu_pkg::OFFSET_BITS-1:0] o_offset
);

    logic                            is_ws;
    logic                            is_x;
    logic                            is_nul;
    logic                            auto_or_hex;
    logic [stu_pkg::BASE_W-1:0]      eff_base;
    stu_pkg::t_digit                 dig;
    logic                            dig_ok;
    logic [stu_pkg::VALUE_W-1:0]     acc_next;
    logic [stu_pkg::OFFSET_BITS-1:0] pos_adv;
    logic                            take;

    // Character classes
    assign is_ws  = (i_char == stu_pkg::CH_SPACE) || (i_char == stu_pkg::CH_TAB)
                 || (i_char == stu_pkg::CH_LF);
    assign is_x   = (i_char == stu_pkg::CH_LX) || (i_char == stu_pkg::CH_UX);
    assign is_nul = (i_char == stu_pkg::CH_NUL);
    assign auto_or_hex = (i_base_mode == stu_pkg::BASE_AUTO)
                      || (i_base_mode == stu_pkg::BASE_HEX);

    // Base in force for a digit decision in this phase
    always_comb begin
        case (i_cur.phase)
            stu_pkg::PH_SKIP: begin
                eff_base = (i_base_mode == stu_pkg::BASE_AUTO) ? stu_pkg::BASE_DEC
                                                               : i_base_mode;
            end
            stu_pkg::PH_ZERO: begin
                eff_base = (i_cur.base == stu_pkg::BASE_AUTO) ? stu_pkg::BASE_OCT
                                                              : stu_pkg::BASE_HEX;
            end
            default: begin
                eff_base = i_cur.base;
            end
        endcase
    end

    // Digit check and multiply-accumulate (64 by 5 bits)
    assign dig      = stu_pkg::digit_decode(i_char);
    assign dig_ok   = dig.ok && ({1'b0, dig.val} < eff_base);
    assign acc_next = stu_pkg::VALUE_W'(i_cur.acc * stu_pkg::VALUE_W'(eff_base))
                    + stu_pkg::VALUE_W'(dig.val);
    assign pos_adv  = (i_cur.pos != stu_pkg::POS_MAX) ? i_cur.pos + stu_pkg::OFFSET_BITS'(1)
                                                      : i_cur.pos;

    // Whether this character goes to the digit decision
    always_comb begin
        case (i_cur.phase)
            stu_pkg::PH_SKIP:   take = !is_ws && !(auto_or_hex && i_char == stu_pkg::CH_ZERO);
            stu_pkg::PH_ZERO:   take = !is_x;
            stu_pkg::PH_DIGITS: take = 1'b1;
            default:            take = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        o_nxt = i_cur;
        case (i_cur.phase)
            stu_pkg::PH_SKIP: begin
                if (is_ws) begin
                    o_nxt.pos = pos_adv;
                end else if (!take) begin
                    o_nxt.base  = i_base_mode;
                    o_nxt.pos   = pos_adv;
                    o_nxt.phase = stu_pkg::PH_ZERO;
                end
            end
            stu_pkg::PH_ZERO: begin
                if (!take) begin
                    o_nxt.base  = stu_pkg::BASE_HEX;
                    o_nxt.pos   = pos_adv;
                    o_nxt.phase = stu_pkg::PH_DIGITS;
                end
            end
            stu_pkg::PH_DIGITS: begin
                o_nxt = i_cur;
            end
            default: begin
                if (is_nul) begin
                    o_nxt.phase = stu_pkg::PH_SKIP;
                    o_nxt.acc   = '0;
                    o_nxt.pos   = '0;
                    o_nxt.base  = stu_pkg::BASE_AUTO;
                end
            end
        endcase
        // Digit decision: accumulate, or end the number
        if (take) begin
            o_nxt.base = eff_base;
            if (dig_ok) begin
                o_nxt.acc   = acc_next;
                o_nxt.pos   = pos_adv;
                o_nxt.phase = stu_pkg::PH_DIGITS;
            end else if (is_nul) begin
                o_nxt.phase = stu_pkg::PH_SKIP;
                o_nxt.acc   = '0;
                o_nxt.pos   = '0;
                o_nxt.base  = stu_pkg::BASE_AUTO;
            end else begin
                o_nxt.phase = stu_pkg::PH_DRAIN;
            end
        end
    end

    // Result
    always_comb begin
        o_emit   = take && !dig_ok;
        o_value  = i_cur.acc;
        o_offset = i_cur.pos;
    end

endmodule
